// ----- rtl/group_reversal_buffer_top_macros.svh -----
// ----------------------------------------------------------------------------
// group reversal buffer assertion macros
// shared concurrent check forms, clocked on clk and idle during reset
// ----------------------------------------------------------------------------
`ifndef GROUP_REVERSAL_BUFFER_TOP_MACROS_SVH
`define GROUP_REVERSAL_BUFFER_TOP_MACROS_SVH

// same-cycle implication
`define GRB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/grb_pkg.sv -----
// ----------------------------------------------------------------------------
// grb_pkg
// shared widths, register codes and front-to-back transfer types
// ----------------------------------------------------------------------------
`default_nettype none

package grb_pkg;

	localparam int DATA_W    = 32;
	localparam int GS_W      = 7;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// register index codes
	localparam logic REG_GROUP_SIZE = 1'b0;

	localparam logic [GS_W-1:0] GS_RESET = 7'd1;

	// one closed group waiting to be emitted
	typedef struct packed {
		logic            bank;
		logic [GS_W-1:0] count;
		logic            fin;
	} grb_desc_t;

	// bank handed back by the emitter
	typedef struct packed {
		logic valid;
		logic bank;
	} grb_rel_t;

endpackage

`default_nettype wire

// ----- rtl/grb_fifo.sv -----
// ----------------------------------------------------------------------------
// grb_fifo
// two-entry descriptor queue between the collecting and emitting sides
// ----------------------------------------------------------------------------
`default_nettype none

module grb_fifo
	import grb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire grb_desc_t push_desc,
	input  wire logic      pop,
	output logic           head_valid,
	output grb_desc_t      head_desc,
	output logic           full
);

	grb_desc_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_valid = (cnt_q != 2'd0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign full       = (cnt_q == 2'd2);

endmodule

`default_nettype wire

// ----- rtl/grb_front.sv -----
// ----------------------------------------------------------------------------
// grb_front
// accepts elements, fills the current bank and closes groups
// ----------------------------------------------------------------------------
`default_nettype none

module grb_front
	import grb_pkg::*;
#(
	parameter int MAX_GROUP = 64,
	parameter int IW        = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [GS_W-1:0]      group_size,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire logic [DATA_W-1:0]    item_value,
	input  wire logic                 item_fin,
	output logic                      wr_en,
	output logic [IW:0]               wr_addr,
	output logic [DATA_W-1:0]         wr_data,
	output logic                      push,
	output grb_desc_t                 push_desc,
	input  wire grb_rel_t             rel
);

	logic [IW-1:0]   fill_q;
	logic            bank_q;
	logic [1:0]      busy_q;
	logic [1:0]      busy_d;
	logic [GS_W-1:0] eff_size;
	logic [GS_W-1:0] new_fill;
	logic            accept;

	always_comb begin
		priority if (group_size == '0) begin
			eff_size = GS_W'(1);
		end else if (group_size > GS_W'(MAX_GROUP)) begin
			eff_size = GS_W'(MAX_GROUP);
		end else begin
			eff_size = group_size;
		end
	end

	assign item_ready = ~busy_q[bank_q];
	assign accept     = item_valid & item_ready;
	assign new_fill   = GS_W'(fill_q) + GS_W'(1);

	assign wr_en   = accept;
	assign wr_addr = {bank_q, fill_q};
	assign wr_data = item_value;

	assign push            = accept & ((new_fill >= eff_size) | item_fin);
	assign push_desc.bank  = bank_q;
	assign push_desc.count = new_fill;
	assign push_desc.fin   = item_fin;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			busy_d[b] = (busy_q[b] & ~(rel.valid & (rel.bank == 1'(b))))
				| (push & (bank_q == 1'(b)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			busy_q <= busy_d;
			if (push) begin
				fill_q <= '0;
				bank_q <= ~bank_q;
			end else if (accept) begin
				fill_q <= IW'(new_fill);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/grb_back.sv -----
// ----------------------------------------------------------------------------
// grb_back
// holds the element banks and emits closed groups newest first
// ----------------------------------------------------------------------------
`default_nettype none

module grb_back
	import grb_pkg::*;
#(
	parameter int IW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IW:0]       wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              head_valid,
	input  wire grb_desc_t         head_desc,
	output logic                   pop,
	output grb_rel_t               rel,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output logic [DATA_W-1:0]      result_value,
	output logic                   result_run_last,
	output logic                   result_seq_last
);

	logic [DATA_W-1:0] mem [2**(IW+1)];

	logic              active_q;
	logic              bank_q;
	logic [IW-1:0]     idx_q;
	logic              fin_q;
	logic              valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              run_last_q;
	logic              seq_last_q;

	logic              cur_valid;
	logic              cur_bank;
	logic [IW-1:0]     cur_idx;
	logic              cur_fin;
	logic              adv;
	logic              issue;
	logic              last;

	always_comb begin
		cur_valid = active_q | head_valid;
		if (active_q) begin
			cur_bank = bank_q;
			cur_idx  = idx_q;
			cur_fin  = fin_q;
		end else begin
			cur_bank = head_desc.bank;
			cur_idx  = IW'(head_desc.count - GS_W'(1));
			cur_fin  = head_desc.fin;
		end
	end

	assign adv       = ~valid_q | result_ready;
	assign issue     = adv & cur_valid;
	assign last      = (cur_idx == '0);
	assign pop       = issue & ~active_q;
	assign rel.valid = issue & last;
	assign rel.bank  = cur_bank;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_q    <= mem[{cur_bank, cur_idx}];
			run_last_q <= last;
			seq_last_q <= last & cur_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bank_q   <= 1'b0;
			idx_q    <= '0;
			fin_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= cur_valid;
			end
			if (issue) begin
				active_q <= ~last;
				bank_q   <= cur_bank;
				idx_q    <= cur_idx - IW'(1);
				fin_q    <= cur_fin;
			end
		end
	end

	assign result_valid    = valid_q;
	assign result_value    = rdata_q;
	assign result_run_last = run_last_q;
	assign result_seq_last = seq_last_q;

endmodule

`default_nettype wire

// ----- rtl/group_reversal_buffer_top.sv -----
// ----------------------------------------------------------------------------
// group_reversal_buffer_top
// reverses a stream of elements in groups of group_size
// ----------------------------------------------------------------------------
// usage:
//   elements enter on the item channel (value, final_element) with
//   item_valid/item_ready; results leave on the result channel (out_value,
//   run_last, sequence_last) with result_valid/result_ready
//   group_size is written through the apb port at byte address 0; the user
//   must write it only while idle, as the block does not enforce it; each
//   element is stored in one of two banks; a group closes when it holds
//   group_size elements or on a final element, and its elements come out
//   newest first, run_last on the last one, sequence_last too if final
//   a closed group reaches the output via the group queue and output register
//   throughput: one element per cycle in and one result per cycle out; the
//   two banks and a two-entry group queue let collection of one group overlap
//   emission of the previous one
//   a receiver stall holds the output register; input stalls only once both
//   banks wait to be emitted
//   reset empties both banks and the queue and sets group_size to 1
// ----------------------------------------------------------------------------
`default_nettype none

`include "group_reversal_buffer_top_macros.svh"

module group_reversal_buffer_top
	import grb_pkg::*;
#(
	parameter int MAX_GROUP = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [PADDR_W-1:0]        paddr,
	input  wire logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]             prdata,
	output logic                           pready,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire logic signed [DATA_W-1:0]  value,
	input  wire logic                      final_element,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic signed [DATA_W-1:0]       out_value,
	output logic                           run_last,
	output logic                           sequence_last
);

	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic [GS_W-1:0]   group_size_q;
	logic              cfg_wr;
	logic              wr_en;
	logic [IW:0]       wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              push;
	grb_desc_t         push_desc;
	logic              pop;
	logic              head_valid;
	grb_desc_t         head_desc;
	logic              fifo_full;
	grb_rel_t          rel;
	logic [DATA_W-1:0] result_value;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_GROUP_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_RESET;
		end else if (cfg_wr) begin
			group_size_q <= pwdata[GS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_GROUP_SIZE) begin
			prdata = PDATA_W'(group_size_q);
		end
	end

	grb_front #(
		.MAX_GROUP (MAX_GROUP),
		.IW        (IW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.group_size (group_size_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_value (DATA_W'(value)),
		.item_fin   (final_element),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push       (push),
		.push_desc  (push_desc),
		.rel        (rel)
	);

	grb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.full       (fifo_full)
	);

	grb_back #(
		.IW (IW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_addr         (wr_addr),
		.wr_data         (wr_data),
		.head_valid      (head_valid),
		.head_desc       (head_desc),
		.pop             (pop),
		.rel             (rel),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result_value    (result_value),
		.result_run_last (run_last),
		.result_seq_last (sequence_last)
	);

	assign out_value = $signed(result_value);

	`GRB_ASSERT_IMP(a_no_push_when_full, push, !fifo_full || pop, "group queue overflow")
	`GRB_ASSERT_IMP(a_push_count_range, push,
		(push_desc.count != '0) && (push_desc.count <= GS_W'(MAX_GROUP)), "bad group count")
	`GRB_ASSERT_IMP(a_final_closes_group, item_valid && item_ready && final_element, push,
		"final element did not close its group")
	`GRB_ASSERT_NEXT(a_pop_fills_output, pop, result_valid, "popped group produced no result")

endmodule

`default_nettype wire
